// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mmft_pkg.sv
// Package with the types, codes and defaults of the multiset mode frequency tracker.
package mmft_pkg;

  localparam int VALUE_RANGE = 1024;
  localparam int COUNT_WIDTH = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  value;
    logic [15:0] divisor;
  } item_t;

  typedef struct packed {
    logic        majority_found;
    logic [15:0] mode_count;
    logic [15:0] element_count;
    logic        op_error;
  } result_t;

  // Hand-off from the table update sequencer to the result stage.
  typedef struct packed {
    logic        fire;
    logic        op_error;
    logic [15:0] divisor;
  } report_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_HIST_OLD,
    ST_HIST_NEW,
    ST_FINISH
  } state_t;

endpackage

// File: sv/multiset_mode_frequency_tracker.sv
// Top level of the multiset mode frequency tracker.
// Usage: an item transfers when start is high and busy is low; its result appears
// on result for exactly one cycle with done high and cannot be held off. An insert
// or remove that changes the tables passes through the count lookup, the two
// dependent read-modify-writes on the histogram table, whose single read port
// serves the old-count and the new-count entries in turn, and the registered
// multiply and compare; a check or a refused item skips the histogram steps. The
// next item is taken only once the result of the last one is out. After reset the
// count table is cleared entry by entry, during which busy stays high.
module multiset_mode_frequency_tracker #(
  parameter int VALUE_RANGE = mmft_pkg::VALUE_RANGE,
  parameter int COUNT_WIDTH = mmft_pkg::COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mmft_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output mmft_pkg::result_t result
);

  localparam int VW = $clog2(VALUE_RANGE);
  localparam int CW = COUNT_WIDTH;

  logic              cnt_we;
  logic [VW-1:0]     cnt_waddr;
  logic [CW-1:0]     cnt_wdata;
  logic [VW-1:0]     cnt_raddr;
  logic [CW-1:0]     cnt_rdata;
  logic              hist_we;
  logic [CW-1:0]     hist_waddr;
  logic [CW-1:0]     hist_wdata;
  logic [CW-1:0]     hist_raddr;
  logic [CW-1:0]     hist_rdata;
  logic [CW-1:0]     mode;
  logic [CW-1:0]     total;
  logic              pending;
  mmft_pkg::report_t report;

  mmft_ram #(
    .WIDTH (CW),
    .DEPTH (VALUE_RANGE)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mmft_ram #(
    .WIDTH (CW),
    .DEPTH (64'd1 << CW)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  mmft_update #(
    .VALUE_RANGE (VALUE_RANGE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .pending    (pending),
    .busy       (busy),
    .cnt_we     (cnt_we),
    .cnt_waddr  (cnt_waddr),
    .cnt_wdata  (cnt_wdata),
    .cnt_raddr  (cnt_raddr),
    .cnt_rdata  (cnt_rdata),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .hist_raddr (hist_raddr),
    .hist_rdata (hist_rdata),
    .mode       (mode),
    .total      (total),
    .report     (report)
  );

  mmft_result #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_result (
    .clk     (clk),
    .rst     (rst),
    .report  (report),
    .mode    (mode),
    .total   (total),
    .pending (pending),
    .done    (done),
    .result  (result)
  );

endmodule

// File: sv/mmft_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mmft_ram #(
  parameter int unsigned     WIDTH = 16,
  parameter longint unsigned DEPTH = 1024,
  localparam int             AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/mmft_update.sv
// Sequencer that clears the count table and does the read-modify-write of both tables.
module mmft_update #(
  parameter int VALUE_RANGE = mmft_pkg::VALUE_RANGE,
  parameter int COUNT_WIDTH = mmft_pkg::COUNT_WIDTH,
  localparam int VW = $clog2(VALUE_RANGE),
  localparam int CW = COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  mmft_pkg::item_t       item,
  input  logic                  pending,
  output logic                  busy,
  output logic                  cnt_we,
  output logic [VW-1:0]         cnt_waddr,
  output logic [CW-1:0]         cnt_wdata,
  output logic [VW-1:0]         cnt_raddr,
  input  logic [CW-1:0]         cnt_rdata,
  output logic                  hist_we,
  output logic [CW-1:0]         hist_waddr,
  output logic [CW-1:0]         hist_wdata,
  output logic [CW-1:0]         hist_raddr,
  input  logic [CW-1:0]         hist_rdata,
  output logic [CW-1:0]         mode,
  output logic [CW-1:0]         total,
  output mmft_pkg::report_t     report
);

  mmft_pkg::state_t state, state_next;

  logic [VW-1:0] clr_addr;
  logic [1:0]    cmd;
  logic [VW-1:0] idx;
  logic          in_range;
  logic [15:0]   divisor;
  logic          op_error;
  logic [CW-1:0] old_cnt;
  logic [CW-1:0] new_cnt;
  // Highest count ever reached; histogram entries above it were never written and are taken as zero.
  logic [CW-1:0] high_water;

  logic          accept;
  logic          is_update;
  logic          is_insert;
  logic          err_now;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] hist_new_val;

  assign busy   = (state != mmft_pkg::ST_IDLE) || pending;
  assign accept = start && !busy;

  always_comb begin
    is_update = cmd inside {mmft_pkg::CMD_INSERT, mmft_pkg::CMD_REMOVE};
    is_insert = (cmd == mmft_pkg::CMD_INSERT);
    if (!is_update) begin
      err_now = 1'b0;
    end else if (!in_range) begin
      err_now = 1'b1;
    end else if (is_insert) begin
      err_now = (total == {CW{1'b1}});
    end else begin
      err_now = (cnt_rdata == '0);
    end
    cnt_next     = is_insert ? cnt_rdata + CW'(1) : cnt_rdata - CW'(1);
    hist_new_val = (new_cnt > high_water) ? '0 : hist_rdata;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mmft_pkg::ST_CLEAR: begin
        if (clr_addr == VW'(VALUE_RANGE - 1)) state_next = mmft_pkg::ST_IDLE;
      end
      mmft_pkg::ST_IDLE: begin
        if (accept) state_next = mmft_pkg::ST_LOOKUP;
      end
      mmft_pkg::ST_LOOKUP: begin
        if (!is_update || err_now) begin
          state_next = mmft_pkg::ST_FINISH;
        end else begin
          state_next = mmft_pkg::ST_HIST_OLD;
        end
      end
      mmft_pkg::ST_HIST_OLD: state_next = mmft_pkg::ST_HIST_NEW;
      mmft_pkg::ST_HIST_NEW: state_next = mmft_pkg::ST_FINISH;
      mmft_pkg::ST_FINISH:   state_next = mmft_pkg::ST_IDLE;
      default:               state_next = mmft_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and the report strobe.
  always_comb begin
    cnt_we      = 1'b0;
    cnt_waddr   = idx;
    cnt_wdata   = cnt_next;
    cnt_raddr   = VW'(item.value);
    hist_we     = 1'b0;
    hist_waddr  = old_cnt;
    hist_wdata  = hist_rdata - CW'(1);
    hist_raddr  = cnt_rdata;
    report.fire     = 1'b0;
    report.op_error = op_error;
    report.divisor  = divisor;
    case (state)
      mmft_pkg::ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        cnt_wdata = '0;
      end
      mmft_pkg::ST_LOOKUP: begin
        cnt_we = is_update && !err_now;
      end
      mmft_pkg::ST_HIST_OLD: begin
        // The value read from entry zero is never used, so it is not maintained.
        hist_we    = (old_cnt != '0);
        hist_raddr = new_cnt;
      end
      mmft_pkg::ST_HIST_NEW: begin
        hist_we    = (new_cnt != '0);
        hist_waddr = new_cnt;
        hist_wdata = hist_new_val + CW'(1);
      end
      mmft_pkg::ST_FINISH: begin
        report.fire = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mmft_pkg::ST_CLEAR;
      clr_addr   <= '0;
      mode       <= '0;
      total      <= '0;
      high_water <= '0;
    end else begin
      state <= state_next;
      if (state == mmft_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + VW'(1);
      end
      if (state == mmft_pkg::ST_HIST_OLD) begin
        // The last value holding the mode count drops by one.
        if (!is_insert && old_cnt == mode && hist_rdata == CW'(1)) begin
          mode <= mode - CW'(1);
        end
      end
      if (state == mmft_pkg::ST_HIST_NEW) begin
        if (is_insert) begin
          total <= total + CW'(1);
          if (new_cnt > mode) mode <= new_cnt;
          if (new_cnt > high_water) high_water <= new_cnt;
        end else begin
          total <= total - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= item.command;
      idx      <= VW'(item.value);
      in_range <= ({7'd0, item.value} < 17'(VALUE_RANGE));
      divisor  <= item.divisor;
    end
    if (state == mmft_pkg::ST_LOOKUP) begin
      op_error <= err_now;
      old_cnt  <= cnt_rdata;
      new_cnt  <= cnt_next;
    end
  end

endmodule

// File: sv/mmft_result.sv
// Result stage: multiplies the mode count by the divisor and forms the result transfer.
module mmft_result #(
  parameter int COUNT_WIDTH = mmft_pkg::COUNT_WIDTH,
  localparam int CW = COUNT_WIDTH,
  localparam int PW = COUNT_WIDTH + 16
) (
  input  logic              clk,
  input  logic              rst,
  input  mmft_pkg::report_t report,
  input  logic [CW-1:0]     mode,
  input  logic [CW-1:0]     total,
  output logic              pending,
  output logic              done,
  output mmft_pkg::result_t result
);

  logic [PW-1:0] product;
  logic [PW-1:0] mode_q;
  logic [PW-1:0] total_q;
  logic          zero_div;
  logic          err_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      done    <= 1'b0;
    end else begin
      pending <= report.fire;
      done    <= pending;
    end
  end

  always_ff @(posedge clk) begin
    if (report.fire) begin
      product  <= PW'(mode) * PW'(report.divisor);
      mode_q   <= PW'(mode);
      total_q  <= PW'(total);
      zero_div <= (report.divisor == 16'd0);
      err_q    <= report.op_error;
    end
    if (pending) begin
      result.majority_found <= zero_div || (product >= total_q);
      result.mode_count     <= mode_q[15:0];
      result.element_count  <= total_q[15:0];
      result.op_error       <= err_q;
    end
  end

endmodule

// File: sv/mmft_checker.sv
// Port-level checker for the multiset mode frequency tracker and its bind.
`include "assert_macros.svh"

module mmft_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input mmft_pkg::item_t   item,
  input logic              busy,
  input logic              done,
  input mmft_pkg::result_t result
);

  // The table clearing pass keeps the block busy right after reset.
  `ASSERT_ALWAYS(a_busy_after_reset, clk, rst |=> busy, "not busy after reset")

  // An item in flight keeps the block busy.
  `ASSERT_CLK(a_busy_after_transfer, clk, rst, (start && !busy) |=> busy, "not busy after transfer")

  // Each item yields one result, so results never come in adjacent cycles.
  `ASSERT_CLK(a_done_single, clk, rst, done |=> !done, "results in adjacent cycles")

  // The highest frequency can never exceed the number of elements held.
  `ASSERT_CLK(a_mode_le_count, clk, rst, done |-> (result.mode_count <= result.element_count), "mode count above element count")

endmodule

bind multiset_mode_frequency_tracker mmft_checker u_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench of the multiset mode frequency tracker: directed and random commands.
module tb_top;
  import mmft_pkg::*;

  // The command field has a fourth code that the block treats as a plain check.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int FULL_TOTAL = 65535;
  localparam int HIST_DEPTH = 65536;
  localparam int RANDOM_ITEMS = 1820;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  item_t item = '0;
  logic busy;
  logic done;
  result_t result;

  multiset_mode_frequency_tracker DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always #5 clk = ~clk;

  // Behavioral copy of the tables, updated when an item transfers.
  logic [15:0] value_tally [0:VALUE_RANGE-1];
  logic [15:0] tally_hist [0:HIST_DEPTH-1];
  logic [15:0] model_mode = '0;
  logic [15:0] model_total = '0;

  function automatic result_t apply_to_multiset(item_t it);
    result_t r;
    logic [15:0] c;
    logic [31:0] product;
    r = '0;
    c = value_tally[it.value];
    case (it.command)
      CMD_INSERT: begin
        if (model_total == 16'hFFFF) begin
          r.op_error = 1'b1;
        end else begin
          tally_hist[c] = tally_hist[c] - 16'd1;
          c = c + 16'd1;
          value_tally[it.value] = c;
          if (c > model_mode) model_mode = c;
          tally_hist[c] = tally_hist[c] + 16'd1;
          model_total = model_total + 16'd1;
        end
      end
      CMD_REMOVE: begin
        if (c == 16'd0) begin
          r.op_error = 1'b1;
        end else begin
          tally_hist[c] = tally_hist[c] - 16'd1;
          // The mode drops by one when the last value holding it loses an element.
          if (tally_hist[model_mode] == 16'd0) model_mode = model_mode - 16'd1;
          c = c - 16'd1;
          value_tally[it.value] = c;
          tally_hist[c] = tally_hist[c] + 16'd1;
          model_total = model_total - 16'd1;
        end
      end
      default: begin
      end
    endcase
    product = model_mode * it.divisor;
    r.majority_found = (it.divisor == 16'd0) || (product >= {16'd0, model_total});
    r.mode_count = model_mode;
    r.element_count = model_total;
    return r;
  endfunction

  // Plan of the stimulus, with a shadow of the multiset so removes can target held values.
  item_t request_queue [$];
  int plan_count [0:VALUE_RANGE-1];
  int plan_held [$];
  int plan_total = 0;

  task automatic plan_item(logic [1:0] cmd, logic [9:0] v, logic [15:0] k);
    item_t it;
    it.command = cmd;
    it.value = v;
    it.divisor = k;
    request_queue.push_back(it);
    if (cmd == CMD_INSERT && plan_total < FULL_TOTAL) begin
      plan_count[v]++;
      plan_held.push_back(int'(v));
      plan_total++;
    end else if (cmd == CMD_REMOVE && plan_count[v] > 0) begin
      plan_count[v]--;
      plan_total--;
      for (int i = plan_held.size() - 1; i >= 0; i--) begin
        if (plan_held[i] == v) begin
          plan_held.delete(i);
          break;
        end
      end
    end
  endtask

  function automatic logic [15:0] pick_divisor();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(2, 6));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [9:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'h3FF;
      2, 3: return 10'($urandom_range(0, 1023));
      default: return 10'($urandom_range(0, 11));
    endcase
  endfunction

  // Driver: bursts of back-to-back requests separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : driver
    logic took;
    took = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        void'(request_queue.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
          if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(20, 60);
        end
      end
      if (start && !took) begin
        // Hold the request until the block takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_queue.size() > 0) begin
        start <= 1'b1;
        item <= request_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each request transfer and checks each result strobe.
  result_t expected_results [$];
  int mismatches = 0;
  int transfers_in = 0;
  int refusals = 0;
  logic [15:0] peak_mode = '0;
  logic [15:0] peak_total = '0;

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, got %p", $time, result);
        end else begin
          want = expected_results.pop_front();
          if (result.majority_found !== want.majority_found) begin
            mismatches++;
            $display("%0t: majority_found expected %0d, got %0d", $time,
                     want.majority_found, result.majority_found);
          end
          if (result.mode_count !== want.mode_count) begin
            mismatches++;
            $display("%0t: mode_count expected %0d, got %0d", $time,
                     want.mode_count, result.mode_count);
          end
          if (result.element_count !== want.element_count) begin
            mismatches++;
            $display("%0t: element_count expected %0d, got %0d", $time,
                     want.element_count, result.element_count);
          end
          if (result.op_error !== want.op_error) begin
            mismatches++;
            $display("%0t: op_error expected %0d, got %0d", $time,
                     want.op_error, result.op_error);
          end
          if (want.op_error) refusals++;
          if (want.mode_count > peak_mode) peak_mode = want.mode_count;
          if (want.element_count > peak_total) peak_total = want.element_count;
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_to_multiset(item));
        transfers_in++;
      end
    end
  end

  // Watchdog: the run is stuck if no transfer happens in either direction for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int roll;
    int insert_share;
    int remove_share;
    for (n = 0; n < VALUE_RANGE; n++) begin
      value_tally[n] = '0;
      plan_count[n] = 0;
    end
    for (n = 0; n < HIST_DEPTH; n++) tally_hist[n] = '0;

    // Directed corners on a small set: empty checks, absent removes, mode drop.
    plan_item(CMD_CHECK, 10'd0, 16'd0);
    plan_item(CMD_CHECK, 10'h3FF, 16'd1);
    plan_item(CMD_REMOVE, 10'd0, 16'd1);
    plan_item(CMD_INSERT, 10'd0, 16'hFFFF);
    plan_item(CMD_INSERT, 10'h3FF, 16'd1);
    plan_item(CMD_INSERT, 10'h3FF, 16'd2);
    plan_item(CMD_INSERT, 10'h2AA, 16'h8000);
    plan_item(CMD_INSERT, 10'h155, 16'd3);
    plan_item(CMD_CHECK, 10'd0, 16'd1);
    plan_item(CMD_CHECK, 10'd0, 16'd2);
    plan_item(CMD_REMOVE, 10'h3FF, 16'd1);
    plan_item(CMD_REMOVE, 10'h3FF, 16'd4);
    plan_item(CMD_REMOVE, 10'h3FF, 16'd1);
    plan_item(CMD_SPARE, 10'h3FF, 16'd0);
    plan_item(CMD_SPARE, 10'h155, 16'h5555);
    plan_item(CMD_REMOVE, 10'h2AA, 16'hAAAA);
    plan_item(CMD_REMOVE, 10'h155, 16'd1);
    plan_item(CMD_REMOVE, 10'd0, 16'd1);
    plan_item(CMD_CHECK, 10'd0, 16'hFFFF);

    // Random part: the first half grows the set, the second half drains it.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      insert_share = (n < RANDOM_ITEMS / 2) ? 60 : 35;
      remove_share = (n < RANDOM_ITEMS / 2) ? 25 : 50;
      roll = $urandom_range(0, 99);
      if (roll < insert_share) begin
        plan_item(CMD_INSERT, pick_value(), pick_divisor());
      end else if (roll < insert_share + remove_share && plan_held.size() > 0) begin
        plan_item(CMD_REMOVE, 10'(plan_held[$urandom_range(0, plan_held.size() - 1)]),
                  pick_divisor());
      end else if (roll < 92) begin
        plan_item(CMD_REMOVE, pick_value(), pick_divisor());
      end else if (roll < 97) begin
        plan_item(CMD_CHECK, 10'($urandom_range(0, 1023)), pick_divisor());
      end else begin
        plan_item(CMD_SPARE, 10'($urandom_range(0, 1023)), pick_divisor());
      end
    end

    // A closing mix of inserts, removes and checks on whatever the set still holds.
    plan_item(CMD_INSERT, 10'd5, 16'd1);
    plan_item(CMD_INSERT, 10'h3FF, 16'hFFFF);
    plan_item(CMD_CHECK, 10'd0, 16'd0);
    plan_item(CMD_CHECK, 10'd0, 16'd1);
    plan_item(CMD_REMOVE, 10'd5, 16'd2);
    plan_item(CMD_INSERT, 10'h2AA, 16'd1);
    plan_item(CMD_INSERT, 10'd0, 16'hFFFF);
    plan_item(CMD_CHECK, 10'h3FF, 16'hFFFF);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (request_queue.size() > 0 || expected_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end

    $display("Sent %0d commands (directed corners and a random grow-then-drain mix);",
             transfers_in);
    $display("%0d were refused, peak mode count %0d, peak element count %0d.",
             refusals, peak_mode, peak_total);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
